// ===== rtl/ttw_pkg.sv =====
package ttw_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 128;

  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 4;
  localparam int OP_W      = 3;
  localparam int POS_IN_W  = 8;
  localparam int POS_OUT_W = 7;

  localparam logic [CFG_W-1:0] COLS_RESET = 8'd80;
  localparam logic [CFG_W-1:0] ROWS_RESET = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd1;

  localparam logic [CHAR_W-1:0] CH_BEL   = 8'd7;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_CHAR   = 3'd0,
    OP_GOTO         = 3'd1,
    OP_CLEAR_SCREEN = 3'd2,
    OP_CLEAR_EOL    = 3'd3,
    OP_READ_CELL    = 3'd4
  } op_t;

endpackage

// ===== rtl/ttw_req_if.sv =====
interface ttw_req_if import ttw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [CHAR_W-1:0]   char_code;
  logic [POS_IN_W-1:0] col;
  logic [POS_IN_W-1:0] row;

  modport source (output valid, operation, char_code, col, row, input ready);
  modport sink (input valid, operation, char_code, col, row, output ready);
endinterface

// ===== rtl/ttw_rsp_if.sv =====
interface ttw_rsp_if import ttw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] cursor_col;
  logic [POS_OUT_W-1:0] cursor_row;
  logic [POS_OUT_W-1:0] top_row;
  logic                 bell;
  logic                 scrolled;
  logic [CHAR_W-1:0]    cell_char;

  modport source (output valid, cursor_col, cursor_row, top_row, bell, scrolled, cell_char,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, top_row, bell, scrolled, cell_char,
                output ready);
endinterface

// ===== rtl/ttw_cfg_if.sv =====
interface ttw_cfg_if import ttw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

// ===== rtl/ttw_ram.sv =====
module ttw_ram import ttw_pkg::*; #(
  parameter int WIDTH = CHAR_W,
  parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/text_terminal_writer_unit.sv =====
// Character cell terminal. Each request yields one result with the cursor, the top row
// pointer, the bell and scroll flags and, for a cell read, the character read. Printable
// characters, line feeds without scrolling, backspace, bell, goto and unused operations
// finish in the execute state; a cell read passes through a read state because of the
// store's registered read. Operations that blank cells walk the single write port one
// cell per cycle: a tab up to the next tab stop or the end of the line, clear to end
// of line from the cursor on, a line feed that scrolls across the new bottom row, and
// clear screen over the whole store of MAX_ROWS * 2**ceil(log2(MAX_COLS)) cells. After
// reset the same sweep fills the store with spaces before the first request is taken;
// configuration writes are taken during that sweep and whenever the block is idle.
module text_terminal_writer_unit import ttw_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ttw_req_if.sink   in_ch,
  ttw_rsp_if.source out_ch,
  ttw_cfg_if.sink   cfg_ch
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW1   = CW + 1;
  localparam int RW1   = RW + 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = MAX_ROWS * (2 ** CW);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SWEEP = 6'b000100,
    S_CLEAR = 6'b001000,
    S_READ  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  function automatic logic [CW:0] fit_cols(logic [CFG_W-1:0] v);
    logic [CW:0] res;
    if (v == '0) begin
      res = CW1'(1);
    end else if (9'(v) > 9'(MAX_COLS)) begin
      res = CW1'(MAX_COLS);
    end else begin
      res = CW1'(v);
    end
    return res;
  endfunction

  function automatic logic [RW:0] fit_rows(logic [CFG_W-1:0] v);
    logic [RW:0] res;
    if (v == '0) begin
      res = RW1'(1);
    end else if (9'(v) > 9'(MAX_ROWS)) begin
      res = RW1'(MAX_ROWS);
    end else begin
      res = RW1'(v);
    end
    return res;
  endfunction

  function automatic logic [RW-1:0] phys_row(logic [RW-1:0] t, logic [RW-1:0] y,
                                             logic [RW:0] r);
    logic [RW:0] s;
    s = {1'b0, t} + {1'b0, y};
    if (s >= r) begin
      s = s - r;
    end
    return s[RW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [CFG_W-1:0]    cols_r, cols_nxt, rows_r, rows_nxt;
  logic [CW-1:0]       cx_r, cx_nxt;
  logic [RW-1:0]       cy_r, cy_nxt, top_r, top_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic [POS_IN_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0]       sw_x_r, sw_x_nxt;
  logic [RW-1:0]       sw_row_r, sw_row_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                clr_rsp_r, clr_rsp_nxt;
  logic                bell_r, bell_nxt, scroll_r, scroll_nxt;
  logic [CHAR_W-1:0]   cell_r, cell_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [POS_OUT_W-1:0] out_col_r, out_row_r, out_top_r;
  logic                 out_bell_r, out_scroll_r;
  logic [CHAR_W-1:0]    out_cell_r;
  logic                 out_load;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  logic [CW:0]   eff_cols, new_cols, cx_inc, sw_inc;
  logic [RW:0]   eff_rows, new_rows, cy_inc, top_inc;
  logic [RW-1:0] cur_row, nl_cy, nl_top, nl_row;
  logic          nl_scroll;
  logic [CHAR_W-1:0] ch_eff;
  logic [POS_IN_W-1:0] goto_x, goto_y;
  logic [CW-1:0] rd_col;
  logic [RW-1:0] rd_row;
  logic          do_nl, done, cfg_fire, cfg_hit, in_fire;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign cfg_fire = cfg_ch.valid & cfg_ch.ready;
  assign cfg_hit  = cfg_fire && (cfg_ch.reg_idx == CFG_COLS || cfg_ch.reg_idx == CFG_ROWS);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = (state_r == S_IDLE) || ((state_r == S_CLEAR) && !clr_rsp_r);

  assign eff_cols = fit_cols(cols_r);
  assign eff_rows = fit_rows(rows_r);

  always_comb begin
    cur_row = phys_row(top_r, cy_r, eff_rows);
    cx_inc  = {1'b0, cx_r} + CW1'(1);
    sw_inc  = {1'b0, sw_x_r} + CW1'(1);
    cy_inc  = {1'b0, cy_r} + RW1'(1);
    top_inc = {1'b0, top_r} + RW1'(1);
    if (cy_inc >= eff_rows) begin
      nl_scroll = 1'b1;
      nl_cy     = RW'(eff_rows - RW1'(1));
      nl_top    = (top_inc >= eff_rows) ? '0 : top_inc[RW-1:0];
    end else begin
      nl_scroll = 1'b0;
      nl_cy     = cy_inc[RW-1:0];
      nl_top    = top_r;
    end
    nl_row = phys_row(nl_top, nl_cy, eff_rows);
    ch_eff = (ch_r == CH_BLANK) ? CH_SPACE : ch_r;
    goto_x = (col_r == '0) ? '0 : col_r - POS_IN_W'(1);
    goto_y = (row_r == '0) ? '0 : row_r - POS_IN_W'(1);
    rd_col = (9'(col_r) >= 9'(eff_cols)) ? CW'(eff_cols - CW1'(1)) : CW'(col_r);
    rd_row = (9'(row_r) >= 9'(eff_rows)) ? RW'(eff_rows - RW1'(1)) : RW'(row_r);
  end

  always_comb begin
    state_nxt    = state_r;
    cols_nxt     = cols_r;
    rows_nxt     = rows_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    top_nxt      = top_r;
    op_nxt       = op_r;
    ch_nxt       = ch_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    sw_x_nxt     = sw_x_r;
    sw_row_nxt   = sw_row_r;
    clr_addr_nxt = clr_addr_r;
    clr_rsp_nxt  = clr_rsp_r;
    bell_nxt     = bell_r;
    scroll_nxt   = scroll_r;
    cell_nxt     = cell_r;
    mem_we       = 1'b0;
    mem_waddr    = {cur_row, cx_r};
    mem_wdata    = CH_SPACE;
    mem_re       = 1'b0;
    mem_raddr    = {phys_row(top_r, rd_row, eff_rows), rd_col};
    do_nl        = 1'b0;
    done         = 1'b0;
    new_cols     = eff_cols;
    new_rows     = eff_rows;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_ch.operation;
          ch_nxt     = in_ch.char_code;
          col_nxt    = in_ch.col;
          row_nxt    = in_ch.row;
          bell_nxt   = 1'b0;
          scroll_nxt = 1'b0;
          cell_nxt   = '0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_t'(op_r))
          OP_WRITE_CHAR: begin
            if (ch_eff == CH_CR || ch_eff == CH_LF) begin
              do_nl = 1'b1;
            end else if (ch_eff == CH_TAB) begin
              mem_we = 1'b1;
              if (cx_inc >= eff_cols) begin
                do_nl = 1'b1;
              end else begin
                cx_nxt = cx_inc[CW-1:0];
                done   = (cx_inc[2:0] == 3'd0);
              end
            end else if (ch_eff == CH_BS) begin
              if (cx_r != '0) begin
                cx_nxt    = cx_r - CW'(1);
                mem_we    = 1'b1;
                mem_waddr = {cur_row, cx_r - CW'(1)};
              end
              done = 1'b1;
            end else if (ch_eff == CH_BEL) begin
              bell_nxt = 1'b1;
              done     = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = ch_eff;
              if (cx_inc >= eff_cols) begin
                do_nl = 1'b1;
              end else begin
                cx_nxt = cx_inc[CW-1:0];
                done   = 1'b1;
              end
            end
          end
          OP_GOTO: begin
            cx_nxt = (9'(goto_x) >= 9'(eff_cols)) ? CW'(eff_cols - CW1'(1)) : CW'(goto_x);
            cy_nxt = (9'(goto_y) >= 9'(eff_rows)) ? RW'(eff_rows - RW1'(1)) : RW'(goto_y);
            done   = 1'b1;
          end
          OP_CLEAR_SCREEN: begin
            cx_nxt       = '0;
            cy_nxt       = '0;
            clr_addr_nxt = '0;
            clr_rsp_nxt  = 1'b1;
            state_nxt    = S_CLEAR;
          end
          OP_CLEAR_EOL: begin
            sw_row_nxt = cur_row;
            sw_x_nxt   = cx_r;
            state_nxt  = S_SWEEP;
          end
          OP_READ_CELL: begin
            mem_re    = 1'b1;
            state_nxt = S_READ;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (do_nl) begin
          cx_nxt  = '0;
          cy_nxt  = nl_cy;
          top_nxt = nl_top;
          if (nl_scroll) begin
            scroll_nxt = 1'b1;
            sw_row_nxt = nl_row;
            sw_x_nxt   = '0;
            state_nxt  = S_SWEEP;
          end else begin
            done = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = {sw_row_r, sw_x_r};
        if (sw_inc >= eff_cols) begin
          done = 1'b1;
        end else begin
          sw_x_nxt = sw_inc[CW-1:0];
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          if (clr_rsp_r) begin
            done = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      S_READ: begin
        cell_nxt = mem_rdata;
        done     = 1'b1;
      end
      S_HOLD: begin
        done = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_hit) begin
      if (cfg_ch.reg_idx == CFG_COLS) begin
        cols_nxt = cfg_ch.wdata;
        new_cols = fit_cols(cfg_ch.wdata);
      end else begin
        rows_nxt = cfg_ch.wdata;
        new_rows = fit_rows(cfg_ch.wdata);
      end
      if ({1'b0, cx_nxt} >= new_cols) begin
        cx_nxt = CW'(new_cols - CW1'(1));
      end
      if ({1'b0, cy_nxt} >= new_rows) begin
        cy_nxt = RW'(new_rows - RW1'(1));
      end
      if ({1'b0, top_nxt} >= new_rows) begin
        top_nxt = '0;
      end
    end

    out_load      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    if (done) begin
      if (!out_valid_r || out_ch.ready) begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cols_r      <= COLS_RESET;
      rows_r      <= ROWS_RESET;
      cx_r        <= '0;
      cy_r        <= '0;
      top_r       <= '0;
      clr_addr_r  <= '0;
      clr_rsp_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      top_r       <= top_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    ch_r     <= ch_nxt;
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    sw_x_r   <= sw_x_nxt;
    sw_row_r <= sw_row_nxt;
    bell_r   <= bell_nxt;
    scroll_r <= scroll_nxt;
    cell_r   <= cell_nxt;
    if (out_load) begin
      out_col_r    <= POS_OUT_W'(cx_nxt);
      out_row_r    <= POS_OUT_W'(cy_nxt);
      out_top_r    <= POS_OUT_W'(top_nxt);
      out_bell_r   <= bell_nxt;
      out_scroll_r <= scroll_nxt;
      out_cell_r   <= cell_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.top_row    = out_top_r;
  assign out_ch.bell       = out_bell_r;
  assign out_ch.scrolled   = out_scroll_r;
  assign out_ch.cell_char  = out_cell_r;

  ttw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("Accepted request did not start execution.");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cx_r} < eff_cols) && ({1'b0, cy_r} < eff_rows) && ({1'b0, top_r} < eff_rows))
    else $error("Cursor or top row outside the screen in use.");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we)
    else $error("Screen store written while idle.");

  a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> $past(mem_re))
    else $error("Cell read data taken without a read.");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
  import ttw_pkg::*;

  localparam int TERM_COLS = MAX_COLS_DEF;
  localparam int TERM_ROWS = MAX_ROWS_DEF;
  localparam int TAB_STOP = 8;
  localparam int IDLE_PCT = 31;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 53;
  localparam int STEADY_PHASE = 2;
  localparam int MAX_CLEARS = 6;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE = 4'd15;

  localparam logic [CFG_W-1:0] PHASE_COLS [PHASES] =
    '{8'd8, 8'd0, 8'd128, 8'd255, 8'd13, 8'd1, 8'd20, 8'd80, 8'd3};
  localparam logic [CFG_W-1:0] PHASE_ROWS [PHASES] =
    '{8'd4, 8'd0, 8'd128, 8'd255, 8'd3, 8'd128, 8'd2, 8'd100, 8'd7};

  typedef struct packed {
    logic [POS_OUT_W-1:0] cursor_col;
    logic [POS_OUT_W-1:0] cursor_row;
    logic [POS_OUT_W-1:0] top_row;
    logic                 bell;
    logic                 scrolled;
    logic [CHAR_W-1:0]    cell_char;
  } term_status_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   char_code;
    logic [POS_IN_W-1:0] col;
    logic [POS_IN_W-1:0] row;
  } term_req_t;

  typedef struct packed {
    term_req_t    req;
    logic         known;
    term_status_t want;
  } dir_row_t;

  // The screen starts at 80 by 100; the expected status is typed in where it is obvious.
  localparam dir_row_t DIRECTED [27] = '{
    '{'{OP_READ_CELL, 8'h00, 8'd0, 8'd0}, 1'b1, '{7'd0, 7'd0, 7'd0, 1'b0, 1'b0, 8'h20}},
    '{'{OP_WRITE_CHAR, 8'h41, 8'd0, 8'd0}, 1'b1, '{7'd1, 7'd0, 7'd0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_READ_CELL, 8'h00, 8'd0, 8'd0}, 1'b1, '{7'd1, 7'd0, 7'd0, 1'b0, 1'b0, 8'h41}},
    '{'{OP_WRITE_CHAR, CH_BEL, 8'd0, 8'd0}, 1'b1, '{7'd1, 7'd0, 7'd0, 1'b1, 1'b0, 8'h00}},
    '{'{OP_WRITE_CHAR, CH_TAB, 8'd0, 8'd0}, 1'b1, '{7'd8, 7'd0, 7'd0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_WRITE_CHAR, CH_BS, 8'd0, 8'd0}, 1'b1, '{7'd7, 7'd0, 7'd0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_WRITE_CHAR, CH_BLANK, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_READ_CELL, 8'h00, 8'd7, 8'd0}, 1'b1, '{7'd8, 7'd0, 7'd0, 1'b0, 1'b0, 8'h20}},
    '{'{OP_GOTO, 8'h00, 8'd0, 8'd0}, 1'b1, '{7'd0, 7'd0, 7'd0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_GOTO, 8'h00, 8'hFF, 8'hFF}, 1'b1, '{7'd79, 7'd99, 7'd0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_WRITE_CHAR, 8'h5A, 8'd0, 8'd0}, 1'b1, '{7'd0, 7'd99, 7'd1, 1'b0, 1'b1, 8'h00}},
    '{'{OP_READ_CELL, 8'h00, 8'd79, 8'd98}, 1'b1, '{7'd0, 7'd99, 7'd1, 1'b0, 1'b0, 8'h5A}},
    '{'{OP_WRITE_CHAR, CH_LF, 8'd0, 8'd0}, 1'b1, '{7'd0, 7'd99, 7'd2, 1'b0, 1'b1, 8'h00}},
    '{'{OP_WRITE_CHAR, CH_CR, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_GOTO, 8'h00, 8'd1, 8'd1}, 1'b0, '0},
    '{'{OP_WRITE_CHAR, 8'h78, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_WRITE_CHAR, 8'h00, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_GOTO, 8'h00, 8'd2, 8'd1}, 1'b0, '0},
    '{'{OP_CLEAR_EOL, 8'h00, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_READ_CELL, 8'h00, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_LAST_UNUSED, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
    '{'{OP_CLEAR_SCREEN, 8'h00, 8'd0, 8'd0}, 1'b1, '{7'd0, 7'd0, 7'd3, 1'b0, 1'b0, 8'h00}},
    '{'{OP_READ_CELL, 8'h00, 8'd0, 8'd0}, 1'b1, '{7'd0, 7'd0, 7'd3, 1'b0, 1'b0, 8'h20}},
    '{'{OP_WRITE_CHAR, CH_BS, 8'd0, 8'd0}, 1'b1, '{7'd0, 7'd0, 7'd3, 1'b0, 1'b0, 8'h00}},
    '{'{OP_GOTO, 8'h00, 8'd78, 8'd1}, 1'b0, '0},
    '{'{OP_WRITE_CHAR, CH_TAB, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_FIRST_UNUSED, 8'h00, 8'd0, 8'd0}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  bit   steady;
  int unsigned mismatch_count;
  term_status_t expected_status [$];

  logic [CHAR_W-1:0] screen_img [TERM_COLS*TERM_ROWS];
  int unsigned cur_x;
  int unsigned cur_y;
  int unsigned top_ptr;
  logic [CFG_W-1:0] cols_reg;
  logic [CFG_W-1:0] rows_reg;
  logic scroll_flag;

  ttw_req_if in_ch();
  ttw_rsp_if out_ch();
  ttw_cfg_if cfg_ch();

  text_terminal_writer_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  function automatic int unsigned active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > TERM_COLS) return TERM_COLS;
    return cols_reg;
  endfunction

  function automatic int unsigned active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > TERM_ROWS) return TERM_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned clamp_below(int unsigned v, int unsigned n);
    return (v >= n) ? n - 1 : v;
  endfunction

  // Logical row y lives in physical row (top_ptr + y) mod height.
  function automatic int unsigned cell_addr(int unsigned x, int unsigned y);
    int unsigned p;
    p = top_ptr + y;
    if (p >= active_rows()) p -= active_rows();
    if (p >= TERM_ROWS) p = TERM_ROWS - 1;
    if (x >= TERM_COLS) x = TERM_COLS - 1;
    return p * TERM_COLS + x;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < TERM_COLS * TERM_ROWS; i++) screen_img[i] = CH_SPACE;
  endfunction

  function automatic void clamp_cursor();
    if (cur_x >= active_cols()) cur_x = active_cols() - 1;
    if (cur_y >= active_rows()) cur_y = active_rows() - 1;
    if (top_ptr >= active_rows()) top_ptr = 0;
  endfunction

  function automatic void next_line();
    cur_x = 0;
    cur_y++;
    if (cur_y >= active_rows()) begin
      cur_y = active_rows() - 1;
      top_ptr++;
      if (top_ptr >= active_rows()) top_ptr = 0;
      for (int x = 0; x < active_cols(); x++) screen_img[cell_addr(x, cur_y)] = CH_SPACE;
      scroll_flag = 1'b1;
    end
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == CFG_COLS) cols_reg = val;
    else if (idx == CFG_ROWS) rows_reg = val;
    else return;
    clamp_cursor();
  endfunction

  function automatic term_status_t terminal_step(term_req_t rq);
    term_status_t st;
    int unsigned w;
    int unsigned h;
    logic [CHAR_W-1:0] code;
    logic ring;
    logic [CHAR_W-1:0] got;
    scroll_flag = 1'b0;
    clamp_cursor();
    w = active_cols();
    h = active_rows();
    ring = 1'b0;
    got = '0;
    case (rq.op)
      OP_WRITE_CHAR: begin
        code = (rq.char_code == CH_BLANK) ? CH_SPACE : rq.char_code;
        if (code == CH_CR || code == CH_LF) begin
          next_line();
        end else if (code == CH_TAB) begin
          // A tab that reaches the width starts a new line, which leaves the column at zero.
          do begin
            screen_img[cell_addr(cur_x, cur_y)] = CH_SPACE;
            cur_x++;
            if (cur_x >= w) next_line();
          end while (cur_x % TAB_STOP != 0);
        end else if (code == CH_BS) begin
          if (cur_x > 0) begin
            cur_x--;
            screen_img[cell_addr(cur_x, cur_y)] = CH_SPACE;
          end
        end else if (code == CH_BEL) begin
          ring = 1'b1;
        end else begin
          screen_img[cell_addr(cur_x, cur_y)] = code;
          cur_x++;
          if (cur_x >= w) next_line();
        end
      end
      OP_GOTO: begin
        cur_x = clamp_below((rq.col == 0) ? 0 : rq.col - 1, w);
        cur_y = clamp_below((rq.row == 0) ? 0 : rq.row - 1, h);
      end
      OP_CLEAR_SCREEN: begin
        blank_screen();
        cur_x = 0;
        cur_y = 0;
      end
      OP_CLEAR_EOL: begin
        for (int x = cur_x; x < w; x++) screen_img[cell_addr(x, cur_y)] = CH_SPACE;
      end
      OP_READ_CELL: begin
        got = screen_img[cell_addr(clamp_below(rq.col, w), clamp_below(rq.row, h))];
      end
      default: begin
      end
    endcase
    st.cursor_col = cur_x[POS_OUT_W-1:0];
    st.cursor_row = cur_y[POS_OUT_W-1:0];
    st.top_row = top_ptr[POS_OUT_W-1:0];
    st.bell = ring;
    st.scrolled = scroll_flag;
    st.cell_char = got;
    return st;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic send_request(term_req_t rq, term_status_t st);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= rq.op;
    in_ch.char_code <= rq.char_code;
    in_ch.col <= rq.col;
    in_ch.row <= rq.row;
    do @(posedge clk); while (!in_ch.ready);
    expected_status.push_back(st);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_idx <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_cfg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    term_status_t exp_st;
    term_status_t got_st;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got_st = '{out_ch.cursor_col, out_ch.cursor_row, out_ch.top_row,
                   out_ch.bell, out_ch.scrolled, out_ch.cell_char};
        if (expected_status.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request pending, expected none, actual %h",
                   $time, got_st);
        end else begin
          exp_st = expected_status.pop_front();
          check_field("cursor_col", exp_st.cursor_col, got_st.cursor_col);
          check_field("cursor_row", exp_st.cursor_row, got_st.cursor_row);
          check_field("top_row", exp_st.top_row, got_st.top_row);
          check_field("bell", exp_st.bell, got_st.bell);
          check_field("scrolled", exp_st.scrolled, got_st.scrolled);
          check_field("cell_char", exp_st.cell_char, got_st.cell_char);
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    term_req_t rq;
    term_status_t st;
    int unsigned clears;
    int unsigned pick;
    rst_n = 1'b0;
    steady = 1'b0;
    mismatch_count = 0;
    clears = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE_CHAR;
    in_ch.char_code = '0;
    in_ch.col = '0;
    in_ch.row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_idx = CFG_COLS;
    cfg_ch.wdata = '0;
    blank_screen();
    cur_x = 0;
    cur_y = 0;
    top_ptr = 0;
    cols_reg = COLS_RESET;
    rows_reg = ROWS_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      st = terminal_step(DIRECTED[i].req);
      if (DIRECTED[i].known) st = DIRECTED[i].want;
      send_request(DIRECTED[i].req, st);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_ch.valid <= 1'b0;
      drain();
      cfg_write(CFG_COLS, PHASE_COLS[p]);
      cfg_write(CFG_ROWS, PHASE_ROWS[p]);
      cfg_write(CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)),
                CFG_W'($urandom_range(255)));
      steady = (p == STEADY_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        rq.char_code = CHAR_W'($urandom_range(255));
        rq.col = POS_IN_W'($urandom_range(255));
        rq.row = POS_IN_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 62) begin
          rq.op = OP_WRITE_CHAR;
          pick = $urandom_range(99);
          if (pick < 12) rq.char_code = CH_LF;
          else if (pick < 18) rq.char_code = CH_CR;
          else if (pick < 28) rq.char_code = CH_TAB;
          else if (pick < 38) rq.char_code = CH_BS;
          else if (pick < 43) rq.char_code = CH_BEL;
          else if (pick < 48) rq.char_code = CH_BLANK;
        end else if (pick < 70) begin
          rq.op = OP_GOTO;
          if ($urandom_range(1) == 1) begin
            rq.col = POS_IN_W'($urandom_range(active_cols() + 1));
            rq.row = POS_IN_W'($urandom_range(active_rows() + 1));
          end
        end else if (pick < 71 && clears < MAX_CLEARS) begin
          rq.op = OP_CLEAR_SCREEN;
          clears++;
        end else if (pick < 78) begin
          rq.op = OP_CLEAR_EOL;
        end else if (pick < 96) begin
          rq.op = OP_READ_CELL;
          if ($urandom_range(3) != 0) begin
            rq.col = POS_IN_W'($urandom_range(active_cols() - 1));
            rq.row = POS_IN_W'($urandom_range(active_rows() - 1));
          end
        end else begin
          rq.op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        end
        st = terminal_step(rq);
        send_request(rq, st);
      end
    end

    in_ch.valid <= 1'b0;
    steady = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
